// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the linearizer RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/plin_pkg.sv =====
// Package for the IR range linearizer: sizes, voltage/distance ROM, codes, types.
// No dependencies.
package plin_pkg;

   localparam int TABLE_ENTRIES = 15;
   localparam int FRACTION_BITS = 8;
   localparam int ROM_SIZE      = 32;
   localparam int N_ENT = (TABLE_ENTRIES < 3) ? 3 :
                          ((TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE : TABLE_ENTRIES);

   localparam int MV_W      = 12;
   localparam int DCM_W     = 10;   // distances in tenths of cm, max 800
   localparam int IDX_W     = $clog2(ROM_SIZE);
   localparam int DIST_W    = 15;
   localparam int STAT_W    = 2;
   localparam int INT_BITS  = 7;    // integer cm below 128
   localparam int NUM_W     = 22;   // dist * span, below 800 * 4095
   localparam int DVS_W     = 16;   // 10 * span
   localparam int QUO_BITS  = FRACTION_BITS + INT_BITS;
   localparam int DVD_W     = NUM_W + FRACTION_BITS;
   localparam int CNT_W     = $clog2(QUO_BITS + 1);

   localparam logic [MV_W-1:0] ROM_MV [ROM_SIZE] = '{
      12'd0, 12'd3090, 12'd3150, 12'd2970, 12'd2740, 12'd2310, 12'd1650, 12'd1310,
      12'd1080, 12'd930, 12'd740, 12'd620, 12'd520, 12'd450, 12'd410, 12'd410,
      12'd410, 12'd410, 12'd410, 12'd410, 12'd410, 12'd410, 12'd410, 12'd410,
      12'd410, 12'd410, 12'd410, 12'd410, 12'd410, 12'd410, 12'd410, 12'd410
   };

   localparam logic [DCM_W-1:0] ROM_DCM [ROM_SIZE] = '{
      10'd0, 10'd50, 10'd61, 10'd70, 10'd80, 10'd100, 10'd150, 10'd200,
      10'd250, 10'd300, 10'd400, 10'd500, 10'd600, 10'd700, 10'd800, 10'd800,
      10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800,
      10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800
   };

   localparam logic [MV_W-1:0]  V_TOP    = ROM_MV[1];
   localparam logic [MV_W-1:0]  V_LAST   = ROM_MV[N_ENT-1];
   localparam logic [IDX_W-1:0] LAST_SEG = IDX_W'(N_ENT - 2);
   localparam longint FAR_FULL = (longint'(ROM_DCM[N_ENT-1]) << FRACTION_BITS) / 10;
   localparam logic [DIST_W-1:0] FAR_Q = DIST_W'(FAR_FULL);

   typedef enum logic [STAT_W-1:0] {
      RS_IN    = 2'd0,
      RS_FAR   = 2'd1,
      RS_CLOSE = 2'd2
   } range_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [QUO_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/plin_div.sv =====
// Restoring divider, one quotient bit per cycle, for the linearizer.
// Depends on plin_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plin_div (
   input  logic                 clock,
   input  logic                 reset,
   input  plin_pkg::div_req_type req,
   output plin_pkg::div_rsp_type rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [plin_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [plin_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [plin_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [plin_pkg::QUO_BITS-1:0] acc_ff, acc_in;
   logic [plin_pkg::DVS_W:0]      trial;
   logic [plin_pkg::DVS_W:0]      diff;
   logic                          ge;

   always_comb begin
      trial   = {rem_ff, acc_ff[plin_pkg::QUO_BITS-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         // quotient fits QUO_BITS, so the upper dividend part is below the divisor
         rem_in  = plin_pkg::DVS_W'(req.dividend[plin_pkg::DVD_W-1:plin_pkg::QUO_BITS]);
         acc_in  = req.dividend[plin_pkg::QUO_BITS-1:0];
         dvs_in  = req.divisor;
         cnt_in  = plin_pkg::CNT_W'(plin_pkg::QUO_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[plin_pkg::DVS_W-1:0] : trial[plin_pkg::DVS_W-1:0];
         acc_in = {acc_ff[plin_pkg::QUO_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == plin_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      acc_ff <= acc_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = acc_ff;

   `AST_IMP(a_start_idle, clock, reset, req.start, !busy_ff)
   `AST_IMP(a_busy_cnt, clock, reset, busy_ff, cnt_ff != '0)
   `AST_NXT(a_start_busy, clock, reset, req.start, busy_ff)

endmodule

// ===== rtl/ir_range_piecewise_linearizer.sv =====
// IR range linearizer top level: sequencer, segment search, multiplies, output register.
// Depends on plin_pkg, plin_div and assert_macros.svh.
//
// Usage:
//   req_valid/req_ready carry one voltage in mV (req_millivolts). rsp_valid/rsp_ready
//   carry the distance in cm with FRACTION_BITS fraction bits (rsp_distance_q8) and a
//   range status (0 in table, 1 too far, 2 too close).
//   One item is processed at a time; req_ready is high only while the sequencer idles.
//   Out-of-range voltages: the sequencer goes from idle straight to the output state,
//   which loads the output register and rsp_valid and then returns to idle.
//   In-range voltages: the sequencer steps through one ROM compare per cycle over the
//   N_ENT - 2 segments, the ST_MUL_A and ST_MUL_B multiply states, the ST_DIV_GO start
//   state, one quotient bit per cycle in the divider until its done strobe, and the
//   output state, which loads the output register and rsp_valid and returns to idle.
//   The result sits in an output register; a new request is taken while it waits.
//   If the receiver stalls, a finished second result holds in the sequencer until
//   the output register frees up.
//   Synchronous reset clears the sequencer and rsp_valid; no warm-up is needed.
`include "assert_macros.svh"

module ir_range_piecewise_linearizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [plin_pkg::MV_W-1:0]     req_millivolts,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [plin_pkg::DIST_W-1:0]   rsp_distance_q8,
   output logic [plin_pkg::STAT_W-1:0]   rsp_range_status
);

   plin_pkg::state_type         state_ff, state_in;
   logic [plin_pkg::MV_W-1:0]   v_ff, v_in;
   logic [plin_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [plin_pkg::IDX_W-1:0]  seg_ff, seg_in;
   logic [plin_pkg::MV_W-1:0]   den_ff, den_in;
   logic [plin_pkg::NUM_W-1:0]  prod_ff, prod_in;
   logic [plin_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [plin_pkg::DIST_W-1:0] res_dist_ff, res_dist_in;
   plin_pkg::range_status_type  res_stat_ff, res_stat_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [plin_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   plin_pkg::range_status_type  rsp_stat_ff, rsp_stat_in;

   logic [plin_pkg::IDX_W-1:0]     idx_nx;
   logic [plin_pkg::IDX_W-1:0]     seg_nx;
   logic [plin_pkg::MV_W-1:0]      dv;
   logic signed [plin_pkg::DCM_W:0] dd;
   logic signed [plin_pkg::NUM_W+2:0] sum;

   plin_pkg::div_req_type div_req;
   plin_pkg::div_rsp_type div_rsp;

   plin_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      idx_nx = idx_ff + 1'b1;
      seg_nx = seg_ff + 1'b1;
      dv     = v_ff - plin_pkg::ROM_MV[seg_nx];
      dd     = $signed({1'b0, plin_pkg::ROM_DCM[seg_ff]})
             - $signed({1'b0, plin_pkg::ROM_DCM[seg_nx]});
      sum    = $signed({3'b000, prod_ff})
             + (plin_pkg::NUM_W+3)'($signed({1'b0, dv})) * (plin_pkg::NUM_W+3)'(dd);

      state_in     = state_ff;
      v_in         = v_ff;
      idx_in       = idx_ff;
      seg_in       = seg_ff;
      den_in       = den_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      res_dist_in  = res_dist_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_stat_in  = rsp_stat_ff;
      req_ready    = 1'b0;

      div_req.start    = 1'b0;
      div_req.dividend = plin_pkg::DVD_W'(num_ff) << plin_pkg::FRACTION_BITS;
      div_req.divisor  = (plin_pkg::DVS_W'(den_ff) << 3) + (plin_pkg::DVS_W'(den_ff) << 1);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         plin_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               v_in   = req_millivolts;
               idx_in = plin_pkg::IDX_W'(1);
               seg_in = '0;
               if (req_millivolts <= plin_pkg::V_LAST) begin
                  res_dist_in = plin_pkg::FAR_Q;
                  res_stat_in = plin_pkg::RS_FAR;
                  state_in    = plin_pkg::ST_OUT;
               end else if (req_millivolts >= plin_pkg::V_TOP) begin
                  res_dist_in = '0;
                  res_stat_in = plin_pkg::RS_CLOSE;
                  state_in    = plin_pkg::ST_OUT;
               end else begin
                  state_in = plin_pkg::ST_SEARCH;
               end
            end
         end
         plin_pkg::ST_SEARCH: begin
            // highest matching segment wins
            if (v_ff <= plin_pkg::ROM_MV[idx_ff] && v_ff > plin_pkg::ROM_MV[idx_nx]) begin
               seg_in = idx_ff;
            end
            idx_in = idx_nx;
            if (idx_ff == plin_pkg::LAST_SEG) begin
               state_in = plin_pkg::ST_MUL_A;
            end
         end
         plin_pkg::ST_MUL_A: begin
            if (seg_ff == '0) begin
               res_dist_in = '0;
               res_stat_in = plin_pkg::RS_IN;
               state_in    = plin_pkg::ST_OUT;
            end else begin
               den_in   = plin_pkg::ROM_MV[seg_ff] - plin_pkg::ROM_MV[seg_nx];
               prod_in  = plin_pkg::NUM_W'(plin_pkg::ROM_DCM[seg_nx])
                        * plin_pkg::NUM_W'(den_in);
               state_in = plin_pkg::ST_MUL_B;
            end
         end
         plin_pkg::ST_MUL_B: begin
            num_in   = (sum < 0) ? '0 : sum[plin_pkg::NUM_W-1:0];
            state_in = plin_pkg::ST_DIV_GO;
         end
         plin_pkg::ST_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = plin_pkg::ST_DIV_WAIT;
         end
         plin_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               res_dist_in = plin_pkg::DIST_W'(div_rsp.quotient);
               res_stat_in = plin_pkg::RS_IN;
               state_in    = plin_pkg::ST_OUT;
            end
         end
         plin_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = res_dist_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = plin_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plin_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plin_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      idx_ff      <= idx_in;
      seg_ff      <= seg_in;
      den_ff      <= den_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      res_dist_ff <= res_dist_in;
      res_stat_ff <= res_stat_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance_q8  = rsp_dist_ff;
   assign rsp_range_status = rsp_stat_ff;

   `AST_IMP(a_far_value, clock, reset, rsp_valid_ff && rsp_stat_ff == plin_pkg::RS_FAR, rsp_dist_ff == plin_pkg::FAR_Q)
   `AST_IMP(a_close_zero, clock, reset, rsp_valid_ff && rsp_stat_ff == plin_pkg::RS_CLOSE, rsp_dist_ff == '0)
   `AST_NXT(a_div_to_out, clock, reset, state_ff == plin_pkg::ST_DIV_WAIT && div_rsp.done, state_ff == plin_pkg::ST_OUT)
   `AST_IMP(a_wait_busy, clock, reset, state_ff == plin_pkg::ST_DIV_WAIT && !div_rsp.done, div_rsp.busy)

endmodule

// ===== tb/sv/ir_range_distance_checker.sv =====
// Checker for the IR range linearizer: watches both channels, predicts distance and
// range status for every voltage transfer, and compares each result transfer in order.
// Depends on plin_pkg (MV_W, DIST_W, STAT_W, range_status_type).
module ir_range_distance_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [plin_pkg::MV_W-1:0]   req_millivolts,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [plin_pkg::DIST_W-1:0] rsp_distance_q8,
   input  logic [plin_pkg::STAT_W-1:0] rsp_range_status,
   output int                          mismatches,
   output int                          outstanding
);

   localparam int KNOTS     = 15;
   localparam int FRAC_BITS = 8;

   typedef struct {
      logic [plin_pkg::MV_W-1:0]   mv;
      logic [plin_pkg::DIST_W-1:0] dist_q8;
      plin_pkg::range_status_type  status;
   } range_result_type;

   // sensor curve: mV and tenths of cm, kept as listed (entry 2 is out of order)
   longint knot_mv [0:KNOTS-1] = '{
      0, 3090, 3150, 2970, 2740, 2310, 1650, 1310, 1080, 930, 740, 620, 520, 450, 410
   };
   longint knot_dcm [0:KNOTS-1] = '{
      0, 50, 61, 70, 80, 100, 150, 200, 250, 300, 400, 500, 600, 700, 800
   };

   range_result_type expected_ranges [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic range_result_type distance_for_mv(logic [plin_pkg::MV_W-1:0] mv);
      range_result_type r;
      int               seg;
      longint           v, vup, vlow, dup, dlow, span, acc;
      r.mv      = mv;
      r.dist_q8 = '0;
      r.status  = plin_pkg::RS_IN;
      v         = longint'(mv);
      seg       = 0;
      if (v <= knot_mv[KNOTS-1]) begin
         r.dist_q8 = plin_pkg::DIST_W'((knot_dcm[KNOTS-1] << FRAC_BITS) / 10);
         r.status  = plin_pkg::RS_FAR;
      end else if (v >= knot_mv[1]) begin
         r.status = plin_pkg::RS_CLOSE;
      end else begin
         // highest matching segment wins
         for (int i = 1; i < KNOTS - 1; i++) begin
            if (v <= knot_mv[i] && v > knot_mv[i+1]) seg = i;
         end
         if (seg != 0) begin
            vup  = knot_mv[seg];
            vlow = knot_mv[seg+1];
            dup  = knot_dcm[seg];
            dlow = knot_dcm[seg+1];
            span = vup - vlow;
            acc  = dlow * span + (v - vlow) * (dup - dlow);
            if (acc < 0) acc = 0;
            r.dist_q8 = plin_pkg::DIST_W'((acc << FRAC_BITS) / (10 * span));
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      range_result_type want;
      if (reset) begin
         expected_ranges.delete();
      end else begin
         if (req_valid && req_ready) expected_ranges.push_back(distance_for_mv(req_millivolts));
         if (rsp_valid && rsp_ready) begin
            if (expected_ranges.size() == 0) begin
               report_mismatch($sformatf("unexpected result transfer: dist %0d status %0d",
                                         rsp_distance_q8, rsp_range_status));
            end else begin
               want = expected_ranges.pop_front();
               if (rsp_distance_q8 !== want.dist_q8)
                  report_mismatch($sformatf("%0d mV: distance_q8 %0d, want %0d",
                                            want.mv, rsp_distance_q8, want.dist_q8));
               if (rsp_range_status !== want.status)
                  report_mismatch($sformatf("%0d mV: range_status %0d, want %0d",
                                            want.mv, rsp_range_status, want.status));
            end
         end
      end
      outstanding = expected_ranges.size();
   end

endmodule

// ===== tb/sv/ir_range_piecewise_linearizer_tb.sv =====
// Testbench top for the IR range linearizer: clock, reset, voltage stimulus, receiver
// stalls and the verdict. Depends on plin_pkg, the linearizer RTL and ir_range_distance_checker.
module ir_range_piecewise_linearizer_tb;

   localparam int RANDOM_ITEMS = 1330;

   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic [plin_pkg::MV_W-1:0]   req_millivolts = '0;
   logic                        rsp_ready      = 1'b0;
   logic                        req_ready;
   logic                        rsp_valid;
   logic [plin_pkg::DIST_W-1:0] rsp_distance_q8;
   logic [plin_pkg::STAT_W-1:0] rsp_range_status;
   int                          mismatches;
   int                          outstanding;
   bit                          calm = 1'b0;
   int                          n_far = 0, n_close = 0, n_in = 0;

   int knots [$] = '{0, 3090, 3150, 2970, 2740, 2310, 1650, 1310, 1080, 930, 740, 620,
                     520, 450, 410};
   int directed_mv [$] = '{0, 4095, 1, 2048, 409, 410, 411, 3089, 3090, 3091, 3150, 3151,
                           2970, 2971, 2969, 2740, 2310, 1650, 1310, 1080, 930, 740, 450,
                           2730, 1365};

   always #4 clock = ~clock;

   ir_range_piecewise_linearizer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_millivolts  (req_millivolts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_distance_q8 (rsp_distance_q8),
      .rsp_range_status(rsp_range_status)
   );

   ir_range_distance_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_millivolts  (req_millivolts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_distance_q8 (rsp_distance_q8),
      .rsp_range_status(rsp_range_status),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always @(negedge clock) begin
      rsp_ready <= reset ? 1'b0 : (calm || $urandom_range(0, 99) >= 8);
   end

   function automatic logic [plin_pkg::MV_W-1:0] pick_voltage();
      int r, v;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         v = $urandom_range(411, 3089);
      end else if (r < 88) begin
         v = knots[$urandom_range(0, knots.size() - 1)] + $urandom_range(0, 4) - 2;
         if (v < 0) v = 0;
      end else begin
         v = $urandom_range(0, 4095);
      end
      return plin_pkg::MV_W'(v);
   endfunction

   task automatic send_voltage(input logic [plin_pkg::MV_W-1:0] mv);
      int gap;
      gap = 0;
      while (!calm && $urandom_range(0, 99) < 8) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_millivolts <= mv;
      if (mv <= 410) n_far++;
      else if (mv >= 3090) n_close++;
      else n_in++;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_mv[k]) send_voltage(plin_pkg::MV_W'(directed_mv[k]));
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         calm = (k >= 300 && k < 600);
         if (k == 700) hold_until_drained();
         send_voltage(pick_voltage());
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (64) @(posedge clock);
      $display("tb: %0d voltages sent: %0d within table, %0d too far, %0d too close",
               n_in + n_far + n_close, n_in, n_far, n_close);
      $display("tb: %0d mismatches seen", mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== ir_range_piecewise_linearizer.f =====
+incdir+rtl
rtl/plin_pkg.sv
rtl/plin_div.sv
rtl/ir_range_piecewise_linearizer.sv
tb/sv/ir_range_distance_checker.sv
tb/sv/ir_range_piecewise_linearizer_tb.sv
